/* rtl/core/aff_inv_pkg.sv */
// Shared constants, types and helpers for the affine inverse core.
`timescale 1ns / 1ps
package aff_inv_pkg;

  localparam int FRAC_BITS = 16;
  // Numerator width: column numerators reach 2^(31+2F), the dot numerator 2^(64+F).
  localparam int NUM_W = 96 + 2 * FRAC_BITS;
  localparam int Q_W = 32;
  // Register stages of one divider lane: the overflow check plus one per quotient bit.
  localparam int DIV_DEPTH = Q_W + 1;
  localparam int LANES = 4;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
    logic       degen;
  } meta_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

/* rtl/core/aff_inv_prep.sv */
// Row front end: magnitudes, squared length, dot product and lane numerators.
`timescale 1ns / 1ps
module aff_inv_prep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  aff_inv_pkg::meta_t               meta_in,
  input  logic [2:0][31:0]                 col,
  input  logic [2:0][31:0]                 off,
  output aff_inv_pkg::meta_t               meta_out,
  output logic [63:0]                      den,
  output logic [aff_inv_pkg::LANES-1:0][aff_inv_pkg::NUM_W-1:0] num,
  output logic [aff_inv_pkg::LANES-1:0]    neg
);

  logic [2:0][31:0] cm_r;
  logic [2:0]       cn_r;
  logic [2:0][63:0] sq_r;
  logic [2:0][63:0] pr_r;
  logic [2:0]       pn_r;
  logic [1:0]       row1_r;
  logic             v1_r;

  aff_inv_pkg::meta_t meta_r;
  logic [63:0]        den_r;
  logic [aff_inv_pkg::LANES-1:0][aff_inv_pkg::NUM_W-1:0] num_r;
  logic [aff_inv_pkg::LANES-1:0] neg_r;

  logic [2:0][31:0] cm_nxt;
  logic [2:0][31:0] tm_nxt;
  logic [63:0]      len2_nxt;
  logic [63:0]      pos_nxt;
  logic [63:0]      negs_nxt;
  logic [63:0]      dmag_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cm_nxt[k] = aff_inv_pkg::mag32(col[k]);
      tm_nxt[k] = aff_inv_pkg::mag32(off[k]);
    end
  end

  always_comb begin
    len2_nxt = sq_r[0] + sq_r[1] + sq_r[2];
    pos_nxt  = 64'd0;
    negs_nxt = 64'd0;
    for (int k = 0; k < 3; k++) begin
      if (pn_r[k]) negs_nxt = negs_nxt + pr_r[k];
      else pos_nxt = pos_nxt + pr_r[k];
    end
    dmag_nxt = (pos_nxt >= negs_nxt) ? (pos_nxt - negs_nxt) : (negs_nxt - pos_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      meta_r.valid <= 1'b0;
    end else if (en) begin
      v1_r <= meta_in.valid;
      meta_r.valid <= v1_r;
      row1_r <= meta_in.row;
      for (int k = 0; k < 3; k++) begin
        cm_r[k] <= cm_nxt[k];
        cn_r[k] <= col[k][31];
        sq_r[k] <= cm_nxt[k] * cm_nxt[k];
        pr_r[k] <= cm_nxt[k] * tm_nxt[k];
        pn_r[k] <= col[k][31] ^ off[k][31];
      end
      meta_r.row   <= row1_r;
      meta_r.degen <= (len2_nxt == 64'd0);
      den_r        <= len2_nxt;
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= aff_inv_pkg::NUM_W'(cm_r[k]) << (2 * aff_inv_pkg::FRAC_BITS);
        neg_r[k] <= cn_r[k];
      end
      // Result is minus the dot: negative when the dot is positive.
      num_r[3] <= aff_inv_pkg::NUM_W'(dmag_nxt) << aff_inv_pkg::FRAC_BITS;
      neg_r[3] <= (pos_nxt > negs_nxt);
    end
  end

  assign meta_out = meta_r;
  assign den      = den_r;
  assign num      = num_r;
  assign neg      = neg_r;

endmodule

/* rtl/core/aff_inv_div.sv */
// Pipelined restoring divider lane with signed saturation to 32 bits.
`timescale 1ns / 1ps
module aff_inv_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [aff_inv_pkg::NUM_W-1:0] num,
  input  logic [63:0]                   den,
  input  logic                          neg,
  output logic [31:0]                   quo
);

  localparam int QW = aff_inv_pkg::Q_W;
  localparam int NW = aff_inv_pkg::NUM_W;

  logic [NW-1:0] rem_r [QW+1];
  logic [63:0]   den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          neg_r [QW+1];
  logic          sat_r [QW+1];

  // Quotients at or above 2^32 saturate regardless of sign.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      sat_r[0] <= (num >= (NW'(den) << QW));
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int K = QW - j;
    logic [NW-1:0] dsh;
    logic          fit;
    assign dsh = NW'(den_r[j-1]) << K;
    assign fit = (rem_r[j-1] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= fit ? (rem_r[j-1] - dsh) : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_r[j-1] | (QW'(fit) << K);
        neg_r[j] <= neg_r[j-1];
        sat_r[j] <= sat_r[j-1];
      end
    end
  end

  logic [QW-1:0] lim;
  always_comb begin
    lim = neg_r[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (sat_r[QW] || (q_r[QW] > lim)) quo = neg_r[QW] ? lim : lim;
    else quo = neg_r[QW] ? (32'd0 - q_r[QW]) : q_r[QW];
  end

endmodule

/* rtl/core/aff_inv_merge.sv */
// Output stage: gathers the four lane quotients into one registered row.
`timescale 1ns / 1ps
module aff_inv_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  aff_inv_pkg::meta_t                   meta,
  input  logic [aff_inv_pkg::LANES-1:0][31:0]  quo,
  output logic                                 out_valid,
  output logic [1:0]                           out_row_index,
  output logic signed [31:0]                   out_col0,
  output logic signed [31:0]                   out_col1,
  output logic signed [31:0]                   out_col2,
  output logic signed [31:0]                   out_col3,
  output logic                                 out_degenerate,
  output logic                                 out_last_row
);

  logic        valid_r;
  logic [1:0]  row_r;
  logic        degen_r;
  logic [aff_inv_pkg::LANES-1:0][31:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (en) valid_r <= meta.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r   <= meta.row;
      degen_r <= meta.degen;
      // Zero-length column: drop the quotients.
      for (int l = 0; l < aff_inv_pkg::LANES; l++)
        col_r[l] <= meta.degen ? 32'd0 : quo[l];
    end
  end

  assign out_valid      = valid_r;
  assign out_row_index  = row_r;
  assign out_col0       = col_r[0];
  assign out_col1       = col_r[1];
  assign out_col2       = col_r[2];
  assign out_col3       = col_r[3];
  assign out_degenerate = degen_r;
  assign out_last_row   = (row_r == aff_inv_pkg::ROW_LAST);

endmodule

/* rtl/core/affine_transform_inverse_core.sv */
// Top level of the affine transform inverse: row sequencer, front end, lanes, output.
//
//  channel | ports                                   | direction
//  input   | in_valid, in_stall, in_axis_*, in_offset_* | matrix in, 12 x Q16.16
//  result  | out_valid, out_stall, out_row_index, out_col0..3, out_degenerate, out_last_row
//
// The row sequencer issues one row per cycle while the result is not stalled.
// A row passes two front-end stages, the 33 stages of each divider lane (an overflow
// check, then one quotient bit a stage) and the output register.
// Synchronous active-low reset clears the valid bits and the row counter only.
// A stalled result freezes the row sequencer, front end, lanes and output, but an idle
// sequencer still takes a matrix; the next matrix is also taken while the current one issues its last row.
`timescale 1ns / 1ps
module affine_transform_inverse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_axis_x_0,
  input  logic signed [31:0] in_axis_x_1,
  input  logic signed [31:0] in_axis_x_2,
  input  logic signed [31:0] in_axis_y_0,
  input  logic signed [31:0] in_axis_y_1,
  input  logic signed [31:0] in_axis_y_2,
  input  logic signed [31:0] in_axis_z_0,
  input  logic signed [31:0] in_axis_z_1,
  input  logic signed [31:0] in_axis_z_2,
  input  logic signed [31:0] in_offset_0,
  input  logic signed [31:0] in_offset_1,
  input  logic signed [31:0] in_offset_2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_degenerate,
  output logic               out_last_row
);

  logic adv;
  logic accept;
  logic issue;

  logic [2:0][2:0][31:0] ax_r;
  logic [2:0][31:0]      off_r;
  logic [1:0]            cnt_r;
  logic                  hv_r;

  assign adv      = !(out_valid && out_stall);
  assign issue    = hv_r && adv;
  assign in_stall = hv_r && !(adv && (cnt_r == aff_inv_pkg::ROW_LAST));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r  <= 1'b0;
      cnt_r <= aff_inv_pkg::ROW_FIRST;
    end else if (accept) begin
      hv_r  <= 1'b1;
      cnt_r <= aff_inv_pkg::ROW_FIRST;
    end else if (issue) begin
      if (cnt_r == aff_inv_pkg::ROW_LAST) hv_r <= 1'b0;
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r[0] <= {in_axis_x_2, in_axis_x_1, in_axis_x_0};
      ax_r[1] <= {in_axis_y_2, in_axis_y_1, in_axis_y_0};
      ax_r[2] <= {in_axis_z_2, in_axis_z_1, in_axis_z_0};
      off_r   <= {in_offset_2, in_offset_1, in_offset_0};
    end
  end

  aff_inv_pkg::meta_t meta_in;
  aff_inv_pkg::meta_t meta_prep;
  logic [2:0][31:0]   col;

  always_comb begin
    meta_in.valid = hv_r;
    meta_in.row   = cnt_r;
    meta_in.degen = 1'b0;
    col           = (cnt_r == aff_inv_pkg::ROW_LAST) ? ax_r[2] :
                    (cnt_r == aff_inv_pkg::ROW_FIRST) ? ax_r[0] : ax_r[1];
  end

  logic [63:0] den;
  logic [aff_inv_pkg::LANES-1:0][aff_inv_pkg::NUM_W-1:0] num;
  logic [aff_inv_pkg::LANES-1:0] neg;
  logic [aff_inv_pkg::LANES-1:0][31:0] quo;

  aff_inv_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .meta_in  (meta_in),
    .col      (col),
    .off      (off_r),
    .meta_out (meta_prep),
    .den      (den),
    .num      (num),
    .neg      (neg)
  );

  for (genvar l = 0; l < aff_inv_pkg::LANES; l++) begin : g_lane
    aff_inv_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num[l]),
      .den (den),
      .neg (neg[l]),
      .quo (quo[l])
    );
  end

  // Row tags ride alongside the divider lanes.
  aff_inv_pkg::meta_t meta_r [aff_inv_pkg::DIV_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < aff_inv_pkg::DIV_DEPTH; s++) meta_r[s].valid <= 1'b0;
    end else if (adv) begin
      meta_r[0] <= meta_prep;
      for (int s = 1; s < aff_inv_pkg::DIV_DEPTH; s++) meta_r[s] <= meta_r[s-1];
    end
  end

  aff_inv_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (adv),
    .meta           (meta_r[aff_inv_pkg::DIV_DEPTH-1]),
    .quo            (quo),
    .out_valid      (out_valid),
    .out_row_index  (out_row_index),
    .out_col0       (out_col0),
    .out_col1       (out_col1),
    .out_col2       (out_col2),
    .out_col3       (out_col3),
    .out_degenerate (out_degenerate),
    .out_last_row   (out_last_row)
  );

endmodule
